### sv/pra_pkg.sv
// Shared types and constants for the partition ready aggregator.
package pra_pkg;

  localparam int IDX_W    = 24;
  localparam int FACTOR_W = 16;
  localparam int ICNT_W   = 9;
  localparam int OIDX_W   = 8;
  localparam int CFG_IW   = 2;
  localparam int STEP_W   = $clog2(IDX_W);

  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_FACTOR    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ICOUNT    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LAST_SIZE = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]    quotient;
    logic [FACTOR_W-1:0] remainder;
  } div_res_t;

endpackage

### sv/partition_ready_aggregator.sv
// Partition ready aggregator top level: sequencer, config registers, result register.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   cmd, public_index
//  out      source     out_valid / out_stall complete, internal_index, range_error
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A mark runs through accept, 24 divider steps, divider done, range check with counter
// read, counter update and result load.
// A clear sweeps the counter memory, then reports.
// After reset the same sweep runs with in_stall high.
// The result register frees the block to take the next item while a result waits.
module partition_ready_aggregator import pra_pkg::*; #(
  parameter int MAX_INTERNAL = 256,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [IDX_W-1:0]    public_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                complete,
  output logic [OIDX_W-1:0]   internal_index,
  output logic                range_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [FACTOR_W-1:0] cfg_data
);

  localparam int AW = (MAX_INTERNAL > 1) ? $clog2(MAX_INTERNAL) : 1;
  localparam int PW = ($clog2(MAX_INTERNAL + 1) > ICNT_W) ? $clog2(MAX_INTERNAL + 1) : ICNT_W;
  localparam int EW = (COUNT_WIDTH > FACTOR_W) ? COUNT_WIDTH : FACTOR_W;
  localparam logic [PW-1:0]          MAX_PARTS = PW'(MAX_INTERNAL);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(MAX_INTERNAL - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t              state;
  logic [FACTOR_W-1:0] factor;
  logic [ICNT_W-1:0]   icount;
  logic [FACTOR_W-1:0] last_size;
  logic [AW-1:0]       clr_addr;
  logic                clr_report;
  logic                is_last;
  logic                res_complete;
  logic [OIDX_W-1:0]   res_idx;
  logic                res_err;

  logic                accept;
  logic                div_start;
  logic                div_done;
  div_res_t            div_res;
  logic [PW-1:0]       parts;
  logic [IDX_W-1:0]    parts_ext;
  logic [IDX_W-1:0]    last_ext;
  logic                oob;
  logic                q_last;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                mem_re;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic                sat;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [FACTOR_W-1:0] expected;
  logic                hit;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign parts = (PW'(icount) > MAX_PARTS) ? MAX_PARTS : PW'(icount);
  assign parts_ext = IDX_W'(parts);
  assign last_ext  = parts_ext - 1'b1;
  assign q_last    = (div_res.quotient == last_ext);
  assign oob = (div_res.quotient >= parts_ext) ||
               (q_last && (div_res.remainder >= last_size));

  assign div_start = accept && (cmd == CMD_MARK) && (parts != '0) && (factor != '0);

  assign sat      = (mem_rdata == CNT_MAX);
  assign cnt_inc  = mem_rdata + 1'b1;
  assign expected = is_last ? last_size : factor;
  assign hit      = !sat && (EW'(cnt_inc) == EW'(expected));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = div_res.quotient[AW-1:0];
    mem_wdata = cnt_inc;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_READ) begin
      mem_we = !sat;
    end
  end

  assign mem_re = (state == ST_CHECK) && !oob;

  pra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (public_index),
    .divisor  (factor),
    .done     (div_done),
    .res      (div_res)
  );

  pra_cnt_mem #(
    .DEPTH (MAX_INTERNAL),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (div_res.quotient[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= FACTOR_W'(1);
      icount    <= ICNT_W'(1);
      last_size <= FACTOR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FACTOR:    factor    <= cfg_data;
        CFG_ICOUNT:    icount    <= cfg_data[ICNT_W-1:0];
        CFG_LAST_SIZE: last_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_complete <= 1'b0;
            res_idx      <= '0;
            if (cmd == CMD_CLEAR) begin
              res_err    <= 1'b0;
              clr_addr   <= '0;
              clr_report <= 1'b1;
              state      <= ST_CLEAR;
            end else if (div_start) begin
              res_err <= 1'b0;
              state   <= ST_DIV;
            end else begin
              res_err <= 1'b1;
              state   <= ST_RESULT;
            end
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= clr_report ? ST_RESULT : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          is_last <= q_last;
          if (oob) begin
            res_err <= 1'b1;
            state   <= ST_RESULT;
          end else begin
            res_idx <= div_res.quotient[OIDX_W-1:0];
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          res_complete <= hit;
          state        <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            complete       <= res_complete;
            internal_index <= res_idx;
            range_error    <= res_err;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_write_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !mem_we)
    else $error("counter write during division");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside division");

  a_clear_next: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_CLEAR) |=> (state == ST_CLEAR))
    else $error("clear transaction did not start sweep");

  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(complete && range_error))
    else $error("completion reported with range error");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> $past(mem_re))
    else $error("counter update without read");

endmodule

### sv/pra_div.sv
// Restoring serial divider, one quotient bit per cycle.
module pra_div import pra_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IDX_W-1:0]    dividend,
  input  logic [FACTOR_W-1:0] divisor,
  output logic                done,
  output div_res_t            res
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [FACTOR_W-1:0] rem;
  logic [IDX_W-1:0]    quo;
  logic [FACTOR_W-1:0] dsr;
  logic [FACTOR_W:0]   trial;
  logic [FACTOR_W:0]   diff;
  logic                ge;

  assign trial = {rem, quo[IDX_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= ge ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
        quo  <= {quo[IDX_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(IDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

### sv/pra_cnt_mem.sv
// Ready counter storage, one write and one registered read port.
module pra_cnt_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
